// ===== rtl/jfhp_pkg.sv =====
// Package: types, marker constants and component tables of the JPEG frame header parser.
`default_nettype none

package jfhp_pkg;

  typedef enum logic [2:0] {
    PH_SOI0,
    PH_SOI1,
    PH_PFX,
    PH_CODE,
    PH_LENH,
    PH_LENL,
    PH_BODY,
    PH_IDLE
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_SOI      = 3'd1,
    ST_BAD_MARKER  = 3'd2,
    ST_UNSUP_FRAME = 3'd3,
    ST_UNSUP_COMP  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FMT_GRAY = 2'd0,
    FMT_NV16 = 2'd1,
    FMT_NV12 = 2'd2
  } pixel_format_e;

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] SoiCode      = 8'hD8;
  localparam logic [7:0] Sof0Code     = 8'hC0;
  localparam logic [7:0] SosCode      = 8'hDA;
  localparam logic [7:0] Precision8   = 8'd8;
  localparam logic [7:0] Samp422      = 8'h21;
  localparam logic [7:0] Samp420      = 8'h22;

  localparam int unsigned ResultW  = 3 + 16 + 16 + 2 + 16;
  localparam int unsigned ResultTw = ((ResultW + 7) / 8) * 8;

  // Result fields, highest first on the bus.
  typedef struct packed {
    logic [15:0] header_length;
    logic [1:0]  pixel_format;
    logic [15:0] height;
    logic [15:0] width;
    logic [2:0]  status;
  } result_t;

  // Expected component bytes of a gray frame, indexed from body byte 6.
  function automatic logic [7:0] gray_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h01;
      2'd1:    val = 8'h11;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Expected component bytes of a 3-component frame; index 1 (luma sampling) is unused.
  function automatic logic [7:0] color_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h01;
      4'd3:    val = 8'h02;
      4'd4:    val = 8'h11;
      4'd5:    val = 8'h01;
      4'd6:    val = 8'h03;
      4'd7:    val = 8'h11;
      4'd8:    val = 8'h01;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jpeg_frame_header_parser.sv =====
// Top level: byte-serial JPEG header parser (SOI, segments, SOF0, SOS) with a result register.
`default_nettype none

// Takes one header byte per cycle on the slave stream; tuser marks byte 0 of a new image and
// restarts the parser. Each byte is handled in the cycle it is accepted, updating the parse
// state, and a finished result (one per image, at the last SOS byte or at the first error)
// goes into a single output register. Throughput is one byte per clock; input tready drops
// only while that output register holds a result the master side has not taken. Bytes after
// a result are absorbed and ignored until the next image start. After reset the next byte is
// treated as byte 0 of an image.
module jpeg_frame_header_parser (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  input  wire logic [7:0]                     s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic                           s_axis_tuser_i,  // [0] first
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [2:0] status, [18:3] width, [34:19] height, [36:35] pixel_format,
  // [52:37] header_length, [55:53] zero
  output      logic [jfhp_pkg::ResultTw-1:0]  m_axis_tdata_o
);

  import jfhp_pkg::*;

  phase_e      phase_q, phase_d, ph_e;
  logic [15:0] seg_off_q, seg_off_d, seg_off_e;
  logic [15:0] seg_len_q, seg_len_d, seg_len_e;
  logic [7:0]  marker_q, marker_d, marker_e;
  logic [15:0] total_q, total_d, total_e;
  logic [15:0] width_q, width_d, width_e;
  logic [15:0] height_q, height_d, height_e;
  logic [7:0]  comp_cnt_q, comp_cnt_d, comp_cnt_e;
  logic [7:0]  luma_q, luma_d, luma_e;
  logic        match_q, match_d, match_e;
  logic [1:0]  fmt_q, fmt_d, fmt_e;

  logic        s_fire;
  logic [7:0]  b;
  logic        active;
  logic        is_c0;
  logic        len_ok;
  logic [15:0] body_len;
  logic [15:0] off_inc;
  logic        seg_done;
  logic        decided;
  logic        emit;
  status_e     status;

  logic        m_valid_q;
  result_t     m_data_q;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;

  // Image start overrides the stored state with the cleared image state.
  always_comb begin
    if (s_axis_tuser_i) begin
      ph_e       = PH_SOI0;
      seg_off_e  = '0;
      seg_len_e  = '0;
      marker_e   = '0;
      total_e    = '0;
      width_e    = '0;
      height_e   = '0;
      comp_cnt_e = '0;
      luma_e     = '0;
      match_e    = 1'b1;
      fmt_e      = FMT_GRAY;
    end else begin
      ph_e       = phase_q;
      seg_off_e  = seg_off_q;
      seg_len_e  = seg_len_q;
      marker_e   = marker_q;
      total_e    = total_q;
      width_e    = width_q;
      height_e   = height_q;
      comp_cnt_e = comp_cnt_q;
      luma_e     = luma_q;
      match_e    = match_q;
      fmt_e      = fmt_q;
    end
  end

  assign active   = (ph_e != PH_IDLE);
  assign is_c0    = (marker_e == Sof0Code);
  assign len_ok   = (seg_len_d >= 16'd2);
  assign body_len = seg_len_d - 16'd2;
  assign off_inc  = seg_off_e + 16'd1;
  assign seg_done = (off_inc >= body_len);
  assign decided  = ((comp_cnt_d == 8'd1) && (body_len >= 16'd9)) ||
                    ((comp_cnt_d == 8'd3) && (body_len >= 16'd15));

  // Datapath: field and counter updates for one byte.
  always_comb begin
    seg_off_d  = seg_off_e;
    seg_len_d  = seg_len_e;
    marker_d   = marker_e;
    total_d    = active ? total_e + 16'd1 : total_e;
    width_d    = width_e;
    height_d   = height_e;
    comp_cnt_d = comp_cnt_e;
    luma_d     = luma_e;
    match_d    = match_e;
    fmt_d      = fmt_e;
    case (ph_e)
      PH_CODE: marker_d = b;
      PH_LENH: seg_len_d = {b, 8'h00};
      PH_LENL: begin
        seg_len_d = {seg_len_e[15:8], b};
        if (seg_len_d >= 16'd2) begin
          seg_off_d = '0;
          if (is_c0) begin
            comp_cnt_d = '0;
            luma_d     = '0;
            match_d    = 1'b1;
          end
        end
      end
      PH_BODY: begin
        seg_off_d = off_inc;
        if (is_c0) begin
          case (seg_off_e)
            16'd0: ;
            16'd1: height_d = {b, 8'h00};
            16'd2: height_d = {height_e[15:8], b};
            16'd3: width_d  = {b, 8'h00};
            16'd4: width_d  = {width_e[15:8], b};
            16'd5: comp_cnt_d = b;
            default: begin
              if (comp_cnt_e == 8'd1) begin
                if (seg_off_e <= 16'd8) begin
                  if (b != gray_byte(2'(seg_off_e - 16'd6))) match_d = 1'b0;
                  if (seg_off_e == 16'd8) fmt_d = FMT_GRAY;
                end
              end else if (seg_off_e <= 16'd14) begin
                if (seg_off_e == 16'd7) begin
                  luma_d = b;
                end else if (b != color_byte(4'(seg_off_e - 16'd6))) begin
                  match_d = 1'b0;
                end
                if (seg_off_e == 16'd14) begin
                  if (luma_e == Samp422)      fmt_d = FMT_NV16;
                  else if (luma_e == Samp420) fmt_d = FMT_NV12;
                end
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // Result decision for one byte.
  always_comb begin
    emit   = 1'b0;
    status = ST_OK;
    unique case (ph_e)
      PH_SOI0: if (b != MarkerPrefix) begin emit = 1'b1; status = ST_NO_SOI; end
      PH_SOI1: if (b != SoiCode)      begin emit = 1'b1; status = ST_NO_SOI; end
      PH_PFX:  if (b != MarkerPrefix) begin emit = 1'b1; status = ST_BAD_MARKER; end
      PH_LENL: begin
        if (!len_ok) begin
          emit   = 1'b1;
          status = ST_BAD_MARKER;
        end else if (seg_len_d == 16'd2) begin
          if (marker_d == SosCode) begin
            emit = 1'b1;
          end else if (is_c0 && !decided) begin
            emit   = 1'b1;
            status = ST_UNSUP_FRAME;
          end
        end
      end
      PH_BODY: begin
        if (is_c0 && seg_off_e == 16'd0 && b != Precision8) begin
          emit   = 1'b1;
          status = ST_UNSUP_FRAME;
        end else if (is_c0 && seg_off_e == 16'd5 && b != 8'd1 && b != 8'd3) begin
          emit   = 1'b1;
          status = ST_UNSUP_COMP;
        end else if (is_c0 && comp_cnt_e == 8'd1 && seg_off_e == 16'd8 && !match_d) begin
          emit   = 1'b1;
          status = ST_UNSUP_FRAME;
        end else if (is_c0 && comp_cnt_e != 8'd1 && seg_off_e == 16'd14 &&
                     (!match_d || (luma_e != Samp422 && luma_e != Samp420))) begin
          emit   = 1'b1;
          status = ST_UNSUP_FRAME;
        end else if (seg_done) begin
          if (marker_d == SosCode) begin
            emit = 1'b1;
          end else if (is_c0 && !decided) begin
            emit   = 1'b1;
            status = ST_UNSUP_FRAME;
          end
        end
      end
      PH_CODE, PH_LENH, PH_IDLE: ;
      default: ;
    endcase
  end

  // Next phase.
  always_comb begin
    phase_d = ph_e;
    if (emit) begin
      phase_d = PH_IDLE;
    end else begin
      unique case (ph_e)
        PH_SOI0: phase_d = PH_SOI1;
        PH_SOI1: phase_d = PH_PFX;
        PH_PFX:  phase_d = PH_CODE;
        PH_CODE: phase_d = PH_LENH;
        PH_LENH: phase_d = PH_LENL;
        PH_LENL: phase_d = (seg_len_d == 16'd2) ? PH_PFX : PH_BODY;
        PH_BODY: phase_d = seg_done ? PH_PFX : PH_BODY;
        PH_IDLE: phase_d = PH_IDLE;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SOI0;
      seg_off_q  <= '0;
      seg_len_q  <= '0;
      marker_q   <= '0;
      total_q    <= '0;
      width_q    <= '0;
      height_q   <= '0;
      comp_cnt_q <= '0;
      luma_q     <= '0;
      match_q    <= 1'b1;
      fmt_q      <= FMT_GRAY;
    end else if (s_fire) begin
      phase_q    <= phase_d;
      seg_off_q  <= seg_off_d;
      seg_len_q  <= seg_len_d;
      marker_q   <= marker_d;
      total_q    <= total_d;
      width_q    <= width_d;
      height_q   <= height_d;
      comp_cnt_q <= comp_cnt_d;
      luma_q     <= luma_d;
      match_q    <= match_d;
      fmt_q      <= fmt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_fire && emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && emit) begin
      m_data_q.status        <= status;
      m_data_q.width         <= width_d;
      m_data_q.height        <= height_d;
      m_data_q.pixel_format  <= (status == ST_OK) ? fmt_d : FMT_GRAY;
      m_data_q.header_length <= (status == ST_OK) ? total_d : 16'd0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(ResultTw - ResultW)'(0), m_data_q};

`ifndef NO_ASSERTIONS
  a_stall_only_on_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_valid_q && !m_axis_tready_i))
    else $error("input stalled without a held result");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(s_fire) && !$past(m_valid_q)) |-> !m_valid_q)
    else $error("result appeared without an accepted item");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q.status != ST_OK) |->
      (m_data_q.pixel_format == FMT_GRAY && m_data_q.header_length == 16'd0))
    else $error("error result carries format or length");

  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && emit) |=> (phase_q == PH_IDLE && m_valid_q))
    else $error("parser not idle after a result");
`endif

endmodule

`default_nettype wire
